### rtl/evg_pkg.sv
// Shared types, constants and the arctangent table of the ellipse vertex generator.
// No dependencies; the modules refer to it by scoped names.
package evg_pkg;

    localparam int MAX_SEGMENTS_DEF = 62;
    localparam int COORD_BITS_DEF   = 24;
    localparam int PHASE_BITS_DEF   = 16;

    localparam int SEG_BITS      = 6;
    localparam int CORDIC_STEPS  = 16;
    localparam int STEP_BITS     = 4;
    localparam int CORDIC_BITS   = 34;
    localparam int TRIG_BITS     = 32;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic signed [CORDIC_BITS-1:0] CORDIC_GAIN  = 34'sd652032874;
    localparam logic signed [CORDIC_BITS-1:0] QUARTER_TURN = 34'sd1073741824;
    localparam logic signed [CORDIC_BITS-1:0] HALF_TURN    = 34'sd2147483648;

    typedef struct packed {
        logic is_center;
        logic last_point;
    } job_ctl_t;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_DIV,
        FR_EMIT,
        FR_CENTER
    } front_state_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_ROT,
        BK_MUL1,
        BK_MUL2,
        BK_SUM,
        BK_OUT
    } back_state_t;

    // atan(2^-k) as a fraction of a turn, 2^32 = one turn
    function automatic logic signed [CORDIC_BITS-1:0] atan_turn(input logic [STEP_BITS-1:0] k);
        logic signed [CORDIC_BITS-1:0] v;
        begin
            unique case (k)
                4'd0:    v = 34'sh020000000;
                4'd1:    v = 34'sh012E4051E;
                4'd2:    v = 34'sh009FB385B;
                4'd3:    v = 34'sh0051111D4;
                4'd4:    v = 34'sh0028B0D43;
                4'd5:    v = 34'sh00145D7E1;
                4'd6:    v = 34'sh000A2F61E;
                4'd7:    v = 34'sh000517C55;
                4'd8:    v = 34'sh00028BE53;
                4'd9:    v = 34'sh000145F2F;
                4'd10:   v = 34'sh0000A2F98;
                4'd11:   v = 34'sh0000517CC;
                4'd12:   v = 34'sh000028BE6;
                4'd13:   v = 34'sh0000145F3;
                4'd14:   v = 34'sh00000A2FA;
                default: v = 34'sh00000517D;
            endcase
            atan_turn = v;
        end
    endfunction

endpackage

### rtl/evg_ellipse_if.sv
// Request channel carrying one ellipse description.
// Depends on nothing; widths come from the instantiating level.
interface evg_ellipse_if #(
    parameter int COORD_BITS = 24,
    parameter int PHASE_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] center_x;
    logic signed [COORD_BITS-1:0] center_y;
    logic signed [COORD_BITS-1:0] half_width;
    logic signed [COORD_BITS-1:0] half_height;
    logic [PHASE_BITS-1:0]        start_phase;
    logic [5:0]                   segment_count;
    logic [15:0]                  scale_x;
    logic [15:0]                  scale_y;

    modport source (
        output valid, center_x, center_y, half_width, half_height,
               start_phase, segment_count, scale_x, scale_y,
        input  ready
    );
    modport sink (
        input  valid, center_x, center_y, half_width, half_height,
               start_phase, segment_count, scale_x, scale_y,
        output ready
    );
endinterface

### rtl/evg_vertex_if.sv
// Result channel carrying one polygon vertex.
// Depends on nothing; widths come from the instantiating level.
interface evg_vertex_if #(
    parameter int COORD_BITS = 24
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic                         is_center;
    logic                         last_point;

    modport source (
        output valid, point_x, point_y, is_center, last_point,
        input  ready
    );
    modport sink (
        input  valid, point_x, point_y, is_center, last_point,
        output ready
    );
endinterface

### rtl/ellipse_polygon_vertex_generator.sv
// Ellipse polygon vertex generator. Each ellipse request yields segment count
// plus one rim vertices (the last repeats the first angle) and then the center,
// flagged is_center and last_point. A count of 0 acts as 1; counts above
// MAX_SEGMENTS are clamped. The front part divides the turn by the count, then
// queues one job per vertex. The back part takes each rim vertex through 16
// CORDIC rotations, two multiply stages, a sum stage and the output load, and
// passes the center straight to the output load. The front accepts the next
// request once it has queued the last job of the current one. Depends on
// evg_pkg, the two channel interfaces, evg_front, evg_job_queue and evg_back.
module ellipse_polygon_vertex_generator #(
    parameter int MAX_SEGMENTS = evg_pkg::MAX_SEGMENTS_DEF,
    parameter int COORD_BITS   = evg_pkg::COORD_BITS_DEF,
    parameter int PHASE_BITS   = evg_pkg::PHASE_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    evg_ellipse_if.sink  ellipse,
    evg_vertex_if.source vertex
);
    localparam int JOB_BITS = 4 * COORD_BITS + 32 + PHASE_BITS + 2;

    logic                q_push_valid, q_push_ready;
    logic [JOB_BITS-1:0] q_push_data;
    logic                q_pop_valid, q_pop_ready;
    logic [JOB_BITS-1:0] q_pop_data;

    evg_front #(
        .COORD_BITS   (COORD_BITS),
        .PHASE_BITS   (PHASE_BITS),
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .JOB_BITS     (JOB_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .ellipse    (ellipse),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_data  (q_push_data)
    );

    evg_job_queue #(
        .WIDTH (JOB_BITS)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_data  (q_push_data),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready),
        .pop_data   (q_pop_data)
    );

    evg_back #(
        .COORD_BITS (COORD_BITS),
        .PHASE_BITS (PHASE_BITS),
        .JOB_BITS   (JOB_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (q_pop_valid),
        .pop_ready (q_pop_ready),
        .pop_data  (q_pop_data),
        .vertex    (vertex)
    );

    // the front never queues jobs while it is open for a new request
    a_idle_no_push: assert property (@(posedge clk) disable iff (!rst_n)
        ellipse.ready |-> !q_push_valid)
        else $error("job pushed while front idle");

    // a request closes the front for at least the following cycle
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        (ellipse.valid && ellipse.ready) |=> !ellipse.ready)
        else $error("front reopened right after request");

    // only the center vertex ends a run
    a_center_last: assert property (@(posedge clk) disable iff (!rst_n)
        vertex.valid |-> (vertex.is_center == vertex.last_point))
        else $error("center and last flags disagree");
endmodule

### rtl/evg_job_queue.sv
// Small FIFO of vertex jobs between the front and back parts.
// Depends on evg_pkg for its depth.
module evg_job_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);
    localparam int DEPTH    = evg_pkg::QUEUE_DEPTH;
    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    entry_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                do_push, do_pop;

    assign push_ready = (count_reg != CNT_BITS'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end
endmodule

### rtl/evg_front.sv
// Front part: takes an ellipse request, divides the turn by the segment count
// and issues one job per rim point plus the center job. Depends on evg_pkg.
module evg_front #(
    parameter int COORD_BITS   = evg_pkg::COORD_BITS_DEF,
    parameter int PHASE_BITS   = evg_pkg::PHASE_BITS_DEF,
    parameter int MAX_SEGMENTS = evg_pkg::MAX_SEGMENTS_DEF,
    parameter int JOB_BITS     = 4 * COORD_BITS + 32 + PHASE_BITS + 2
) (
    input  logic                clk,
    input  logic                rst_n,
    evg_ellipse_if.sink         ellipse,
    output logic                push_valid,
    input  logic                push_ready,
    output logic [JOB_BITS-1:0] push_data
);
    localparam int SB       = evg_pkg::SEG_BITS;
    localparam int CNT_BITS = $clog2(PHASE_BITS + 1);

    evg_pkg::front_state_t state_reg, state_next;

    logic signed [COORD_BITS-1:0] cx_reg, cy_reg, w_reg, h_reg;
    logic [15:0]                  sx_reg, sy_reg;
    logic [PHASE_BITS-1:0]        start_reg;
    logic [SB-1:0]                n_reg, n_next;
    logic [PHASE_BITS:0]          quo_reg, quo_next;
    logic [SB-1:0]                rem_reg, rem_next;
    logic [CNT_BITS-1:0]          cnt_reg, cnt_next;
    logic [PHASE_BITS:0]          off_reg, off_next;
    logic [SB-1:0]                acc_reg, acc_next;
    logic [SB-1:0]                idx_reg, idx_next;

    logic                 accept, pushed;
    logic [SB:0]          rem_shift;
    logic                 div_bit;
    logic [SB:0]          acc_sum;
    logic [SB-1:0]        seg_clamped;
    evg_pkg::job_ctl_t    ctl;
    logic [PHASE_BITS-1:0] phase;

    assign accept = ellipse.valid && ellipse.ready;
    assign pushed = push_valid && push_ready;

    always_comb
    begin
        if (ellipse.segment_count == '0)
        begin
            seg_clamped = SB'(1);
        end
        else if (ellipse.segment_count > SB'(MAX_SEGMENTS))
        begin
            seg_clamped = SB'(MAX_SEGMENTS);
        end
        else
        begin
            seg_clamped = ellipse.segment_count;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            evg_pkg::FR_IDLE:   if (accept) state_next = evg_pkg::FR_DIV;
            evg_pkg::FR_DIV:    if (cnt_reg == '0) state_next = evg_pkg::FR_EMIT;
            evg_pkg::FR_EMIT:   if (pushed && idx_reg == n_reg) state_next = evg_pkg::FR_CENTER;
            evg_pkg::FR_CENTER: if (pushed) state_next = evg_pkg::FR_IDLE;
            default:            state_next = evg_pkg::FR_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        ellipse.ready = 1'b0;
        push_valid    = 1'b0;
        ctl           = '{is_center: 1'b0, last_point: 1'b0};
        unique case (state_reg)
            evg_pkg::FR_IDLE:   ellipse.ready = 1'b1;
            evg_pkg::FR_DIV:    ;
            evg_pkg::FR_EMIT:   push_valid = 1'b1;
            evg_pkg::FR_CENTER:
            begin
                push_valid = 1'b1;
                ctl        = '{is_center: 1'b1, last_point: 1'b1};
            end
            default:            ;
        endcase
    end

    assign phase     = start_reg + off_reg[PHASE_BITS-1:0];
    assign push_data = {cx_reg, cy_reg, w_reg, h_reg, sx_reg, sy_reg, phase, ctl};

    // restoring division of one turn by the segment count, one bit a cycle
    assign div_bit   = (cnt_reg == CNT_BITS'(PHASE_BITS));
    assign rem_shift = {rem_reg, div_bit};
    assign acc_sum   = {1'b0, acc_reg} + {1'b0, rem_reg};

    always_comb
    begin
        n_next   = n_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        off_next = off_reg;
        acc_next = acc_reg;
        idx_next = idx_reg;
        unique case (state_reg)
            evg_pkg::FR_IDLE:
            begin
                n_next   = seg_clamped;
                quo_next = '0;
                rem_next = '0;
                cnt_next = CNT_BITS'(PHASE_BITS);
                off_next = '0;
                acc_next = '0;
                idx_next = '0;
            end
            evg_pkg::FR_DIV:
            begin
                if (rem_shift >= {1'b0, n_reg})
                begin
                    rem_next = SB'(rem_shift - {1'b0, n_reg});
                    quo_next = {quo_reg[PHASE_BITS-1:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_shift[SB-1:0];
                    quo_next = {quo_reg[PHASE_BITS-1:0], 1'b0};
                end
                cnt_next = cnt_reg - 1'b1;
            end
            evg_pkg::FR_EMIT:
            begin
                // advance offset by turn/n, carrying the fractional remainder
                if (pushed)
                begin
                    idx_next = idx_reg + 1'b1;
                    if (acc_sum >= {1'b0, n_reg})
                    begin
                        acc_next = SB'(acc_sum - {1'b0, n_reg});
                        off_next = off_reg + quo_reg + 1'b1;
                    end
                    else
                    begin
                        acc_next = acc_sum[SB-1:0];
                        off_next = off_reg + quo_reg;
                    end
                end
            end
            evg_pkg::FR_CENTER: ;
            default:            ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= evg_pkg::FR_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cx_reg    <= ellipse.center_x;
            cy_reg    <= ellipse.center_y;
            w_reg     <= ellipse.half_width;
            h_reg     <= ellipse.half_height;
            sx_reg    <= ellipse.scale_x;
            sy_reg    <= ellipse.scale_y;
            start_reg <= ellipse.start_phase;
        end
        n_reg   <= n_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
        off_reg <= off_next;
        acc_reg <= acc_next;
        idx_reg <= idx_next;
    end
endmodule

### rtl/evg_back.sv
// Back part: runs CORDIC for each rim job, scales and offsets the result and
// holds it in the output register. Depends on evg_pkg and evg_vertex_if.
module evg_back #(
    parameter int COORD_BITS = evg_pkg::COORD_BITS_DEF,
    parameter int PHASE_BITS = evg_pkg::PHASE_BITS_DEF,
    parameter int JOB_BITS   = 4 * COORD_BITS + 32 + PHASE_BITS + 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pop_valid,
    output logic                pop_ready,
    input  logic [JOB_BITS-1:0] pop_data,
    evg_vertex_if.source        vertex
);
    localparam int CB  = COORD_BITS;
    localparam int KB  = evg_pkg::CORDIC_BITS;
    localparam int TB  = evg_pkg::TRIG_BITS;
    localparam int STB = evg_pkg::STEP_BITS;
    localparam int P1B = CB + TB;        // radius * trig
    localparam int PW  = CB + 16;        // rounded first product
    localparam int HB  = PW - 24;        // upper slice of it
    localparam int LOB = 40;             // 24 x 16 unsigned
    localparam int HIB = HB + 17;        // signed slice x scale
    localparam int SW  = CB + 34;
    localparam int P2B = SW - 26;
    localparam int VB  = P2B + 1;

    evg_pkg::back_state_t state_reg, state_next;

    logic signed [CB-1:0]       j_cx, j_cy, j_w, j_h;
    logic [15:0]                j_sx, j_sy;
    logic [PHASE_BITS-1:0]      j_phase;
    evg_pkg::job_ctl_t          j_ctl;

    logic signed [CB-1:0]       cx_reg, cy_reg, w_reg, h_reg;
    logic [15:0]                sx_reg, sy_reg;
    logic signed [KB-1:0]       x_reg, y_reg, t_reg;
    logic signed [KB-1:0]       x_next, y_next, t_next;
    logic                       neg_reg, neg_next;
    logic [STB-1:0]             step_reg, step_next;
    logic signed [P1B-1:0]      p1x_reg, p1y_reg;
    logic [LOB-1:0]             lox_reg, loy_reg;
    logic signed [HIB-1:0]      hix_reg, hiy_reg;
    logic signed [CB-1:0]       res_x_reg, res_x_next, res_y_reg, res_y_next;
    logic                       res_c_reg, res_c_next;

    logic                       out_valid_reg, out_valid_next;
    logic signed [CB-1:0]       out_x_reg, out_y_reg;
    logic                       out_c_reg;

    logic                       popped, out_free, load_out;
    logic signed [KB-1:0]       angle, t_fold;
    logic                       fold_neg;
    logic signed [KB-1:0]       xs, ys, cos_v, sin_v;
    logic signed [TB-1:0]       cos_t, sin_t;
    logic signed [P1B-1:0]      p1x_rnd, p1y_rnd;
    logic signed [PW-1:0]       p1x, p1y;
    logic signed [SW-1:0]       sum_x, sum_y;
    logic signed [P2B-1:0]      p2x, p2y;
    logic signed [VB-1:0]       vx, vy;

    assign {j_cx, j_cy, j_w, j_h, j_sx, j_sy, j_phase, j_ctl} = pop_data;

    assign popped   = pop_valid && pop_ready;
    assign out_free = !out_valid_reg || vertex.ready;
    assign load_out = (state_reg == evg_pkg::BK_OUT) && out_free;

    // fold the angle into [-1/4, +1/4] turn, negating both results when folded
    assign angle = KB'($signed({j_phase, {(32 - PHASE_BITS){1'b0}}}));
    always_comb
    begin
        t_fold   = angle;
        fold_neg = 1'b0;
        if (angle > evg_pkg::QUARTER_TURN)
        begin
            t_fold   = angle - evg_pkg::HALF_TURN;
            fold_neg = 1'b1;
        end
        else if (angle < -evg_pkg::QUARTER_TURN)
        begin
            t_fold   = angle + evg_pkg::HALF_TURN;
            fold_neg = 1'b1;
        end
    end

    assign xs    = x_reg >>> step_reg;
    assign ys    = y_reg >>> step_reg;
    assign cos_v = neg_reg ? -x_reg : x_reg;
    assign sin_v = neg_reg ? -y_reg : y_reg;
    assign cos_t = cos_v[TB-1:0];
    assign sin_t = sin_v[TB-1:0];

    assign p1x_rnd = p1x_reg + P1B'(32768);
    assign p1y_rnd = p1y_reg + P1B'(32768);
    assign p1x     = p1x_rnd[P1B-1:16];
    assign p1y     = p1y_rnd[P1B-1:16];

    assign sum_x = (SW'(hix_reg) <<< 24) + $signed(SW'(lox_reg)) + SW'(33554432);
    assign sum_y = (SW'(hiy_reg) <<< 24) + $signed(SW'(loy_reg)) + SW'(33554432);
    assign p2x   = sum_x[SW-1:26];
    assign p2y   = sum_y[SW-1:26];
    assign vx    = VB'(cx_reg) + VB'(p2x);
    assign vy    = VB'(cy_reg) + VB'(p2y);

    function automatic logic signed [CB-1:0] sat(input logic signed [VB-1:0] v);
        logic signed [VB-1:0] hi, lo;
        begin
            hi = VB'({1'b0, {(CB - 1){1'b1}}});
            lo = ~hi;
            if (v > hi)
            begin
                sat = hi[CB-1:0];
            end
            else if (v < lo)
            begin
                sat = lo[CB-1:0];
            end
            else
            begin
                sat = v[CB-1:0];
            end
        end
    endfunction

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            evg_pkg::BK_IDLE:
            begin
                if (popped)
                begin
                    state_next = j_ctl.is_center ? evg_pkg::BK_OUT : evg_pkg::BK_ROT;
                end
            end
            evg_pkg::BK_ROT:  if (step_reg == STB'(evg_pkg::CORDIC_STEPS - 1)) state_next = evg_pkg::BK_MUL1;
            evg_pkg::BK_MUL1: state_next = evg_pkg::BK_MUL2;
            evg_pkg::BK_MUL2: state_next = evg_pkg::BK_SUM;
            evg_pkg::BK_SUM:  state_next = evg_pkg::BK_OUT;
            evg_pkg::BK_OUT:  if (out_free) state_next = evg_pkg::BK_IDLE;
            default:          state_next = evg_pkg::BK_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        pop_ready = 1'b0;
        unique case (state_reg)
            evg_pkg::BK_IDLE: pop_ready = 1'b1;
            default:          pop_ready = 1'b0;
        endcase
    end

    // datapath
    always_comb
    begin
        x_next     = x_reg;
        y_next     = y_reg;
        t_next     = t_reg;
        neg_next   = neg_reg;
        step_next  = step_reg;
        res_x_next = res_x_reg;
        res_y_next = res_y_reg;
        res_c_next = res_c_reg;
        unique case (state_reg)
            evg_pkg::BK_IDLE:
            begin
                x_next     = evg_pkg::CORDIC_GAIN;
                y_next     = '0;
                t_next     = t_fold;
                neg_next   = fold_neg;
                step_next  = '0;
                res_x_next = j_cx;
                res_y_next = j_cy;
                res_c_next = j_ctl.is_center;
            end
            evg_pkg::BK_ROT:
            begin
                if (t_reg >= 0)
                begin
                    x_next = x_reg - ys;
                    y_next = y_reg + xs;
                    t_next = t_reg - evg_pkg::atan_turn(step_reg);
                end
                else
                begin
                    x_next = x_reg + ys;
                    y_next = y_reg - xs;
                    t_next = t_reg + evg_pkg::atan_turn(step_reg);
                end
                step_next = step_reg + 1'b1;
            end
            evg_pkg::BK_SUM:
            begin
                res_x_next = sat(vx);
                res_y_next = sat(vy);
            end
            default: ;
        endcase
    end

    assign out_valid_next = load_out ? 1'b1 : (vertex.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= evg_pkg::BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (popped)
        begin
            cx_reg <= j_cx;
            cy_reg <= j_cy;
            w_reg  <= j_w;
            h_reg  <= j_h;
            sx_reg <= j_sx;
            sy_reg <= j_sy;
        end
        x_reg     <= x_next;
        y_reg     <= y_next;
        t_reg     <= t_next;
        neg_reg   <= neg_next;
        step_reg  <= step_next;
        res_x_reg <= res_x_next;
        res_y_reg <= res_y_next;
        res_c_reg <= res_c_next;
        if (state_reg == evg_pkg::BK_MUL1)
        begin
            p1x_reg <= P1B'(w_reg) * P1B'(cos_t);
            p1y_reg <= P1B'(h_reg) * P1B'(sin_t);
        end
        if (state_reg == evg_pkg::BK_MUL2)
        begin
            lox_reg <= LOB'(p1x[23:0]) * LOB'(sx_reg);
            loy_reg <= LOB'(p1y[23:0]) * LOB'(sy_reg);
            hix_reg <= HIB'($signed(p1x[PW-1:24])) * $signed(HIB'({1'b0, sx_reg}));
            hiy_reg <= HIB'($signed(p1y[PW-1:24])) * $signed(HIB'({1'b0, sy_reg}));
        end
        if (load_out)
        begin
            out_x_reg <= res_x_reg;
            out_y_reg <= res_y_reg;
            out_c_reg <= res_c_reg;
        end
    end

    assign vertex.valid      = out_valid_reg;
    assign vertex.point_x    = out_x_reg;
    assign vertex.point_y    = out_y_reg;
    assign vertex.is_center  = out_c_reg;
    assign vertex.last_point = out_c_reg;
endmodule
